### rtl/core/npc_pkg.sv
// Package of the nested priority interrupt controller: sizes, codes, item types
// and the priority lookup. Used by nested_interrupt_priority_controller_core.
package npc_pkg;

  localparam int unsigned NEST_DEPTH    = 16;
  localparam int unsigned PENDING_DEPTH = 16;
  localparam int unsigned NUM_VECTORS   = 16;

  localparam int unsigned NEST_AW = $clog2(NEST_DEPTH);
  localparam int unsigned NEST_CW = $clog2(NEST_DEPTH + 1);
  localparam int unsigned PEND_AW = $clog2(PENDING_DEPTH);
  localparam int unsigned PEND_CW = $clog2(PENDING_DEPTH + 1);

  localparam int unsigned VEC_W   = 4;
  localparam int unsigned PRIO_W  = 4;
  localparam int unsigned STAMP_W = 8;
  localparam int unsigned PEND_W  = STAMP_W + VEC_W;

  localparam int unsigned PADDR_W = 3;

  typedef enum logic [1:0] {
    FUNC_HW_REQ = 2'd0,
    FUNC_SW_ENTRY = 2'd1,
    FUNC_RETURN = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_PENDING_FULL = 2'd1,
    ERR_NEST_FULL = 2'd2,
    ERR_NOTHING_ACTIVE = 2'd3
  } err_e;

  typedef enum logic {
    REG_PRIO_LOW = 1'b0,
    REG_PRIO_HIGH = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [VEC_W-1:0] vector;
  } in_item_t;

  typedef struct packed {
    logic             dispatched;
    logic [VEC_W-1:0] dispatched_vector;
    logic             from_pending;
    logic             queued;
    logic [1:0]       error_code;
    logic [4:0]       active_depth;
  } out_item_t;

  // Four-bit priority of a vector from the two priority registers.
  function automatic logic [PRIO_W-1:0] prio_of(input logic [31:0] lo,
                                               input logic [31:0] hi,
                                               input logic [VEC_W-1:0] vec);
    logic [31:0] word;
    word = vec[3] ? hi : lo;
    return word[{vec[2:0], 2'b00} +: PRIO_W];
  endfunction

endpackage

### rtl/core/nested_interrupt_priority_controller_core.sv
// Nested priority interrupt controller. Each item is a hardware request, a
// software entry or a return, and gives one result item. Hardware requests,
// software entries, invalid events and returns that find nothing active or no
// pending request go from the read state straight to the result. A return that
// finds requests pending walks the pending store one entry per cycle through
// its single read port to find the best request, and when it dispatches that
// request closes the store up one entry per cycle. The next item can be taken
// in the cycle after the result is loaded; loading waits while the result side
// stalls. Depends on npc_pkg and npc_ram.
module nested_interrupt_priority_controller_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  npc_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output npc_pkg::out_item_t        out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [npc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned NAW = npc_pkg::NEST_AW;
  localparam int unsigned NCW = npc_pkg::NEST_CW;
  localparam int unsigned PAW = npc_pkg::PEND_AW;
  localparam int unsigned PCW = npc_pkg::PEND_CW;
  localparam int unsigned VW  = npc_pkg::VEC_W;
  localparam int unsigned PW  = npc_pkg::PRIO_W;

  npc_pkg::state_e    state_q, state_d;
  logic [1:0]         func_q, func_d;
  logic [VW-1:0]      vec_q, vec_d;
  logic [31:0]        prio_lo_q, prio_hi_q;
  logic [NCW-1:0]     hw_cnt_q, hw_cnt_d;
  logic [NCW-1:0]     nest_cnt_q, nest_cnt_d;
  logic [PCW-1:0]     pend_cnt_q, pend_cnt_d;
  logic [7:0]         arr_q, arr_d;
  logic [PAW-1:0]     scan_idx_q, scan_idx_d;
  logic [PAW-1:0]     best_idx_q, best_idx_d;
  logic [PW-1:0]      best_prio_q, best_prio_d;
  logic [VW-1:0]      best_vec_q, best_vec_d;
  logic [PCW-1:0]     shift_idx_q, shift_idx_d;
  npc_pkg::out_item_t res_q, res_d;
  npc_pkg::out_item_t out_q;
  logic               out_valid_q;

  logic               in_accept, out_load, cfg_write;

  logic               hw_we, kind_we, pend_we;
  logic [NAW-1:0]     hw_waddr, kind_waddr;
  logic [VW-1:0]      hw_wdata, hw_rdata;
  logic               kind_wdata, kind_rdata;
  logic [PAW-1:0]     pend_waddr, pend_raddr;
  logic [npc_pkg::PEND_W-1:0] pend_wdata, pend_rdata;

  logic               vec_ok, hw_outranks, pend_outranks, pend_better;
  logic [PW-1:0]      scan_prio;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (npc_pkg::reg_e'(paddr[2]) == npc_pkg::REG_PRIO_HIGH) ? prio_hi_q
                                                                          : prio_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_lo_q <= '0;
      prio_hi_q <= '0;
    end else if (cfg_write) begin
      unique case (npc_pkg::reg_e'(paddr[2]))
        npc_pkg::REG_PRIO_LOW:  prio_lo_q <= pwdata;
        npc_pkg::REG_PRIO_HIGH: prio_hi_q <= pwdata;
        default:                prio_lo_q <= prio_lo_q;
      endcase
    end
  end

  // Stacks and pending store. The stack read addresses follow the counts, so the
  // top entries are ready in the cycle after any count change.
  npc_ram #(.WIDTH(VW), .DEPTH(npc_pkg::NEST_DEPTH)) u_hw_stack (
    .clk_i  (clk_i),
    .we_i   (hw_we),
    .waddr_i(hw_waddr),
    .wdata_i(hw_wdata),
    .raddr_i(NAW'(hw_cnt_q - NCW'(1))),
    .rdata_o(hw_rdata)
  );

  npc_ram #(.WIDTH(1), .DEPTH(npc_pkg::NEST_DEPTH)) u_kind_stack (
    .clk_i  (clk_i),
    .we_i   (kind_we),
    .waddr_i(kind_waddr),
    .wdata_i(kind_wdata),
    .raddr_i(NAW'(nest_cnt_q - NCW'(1))),
    .rdata_o(kind_rdata)
  );

  npc_ram #(.WIDTH(npc_pkg::PEND_W), .DEPTH(npc_pkg::PENDING_DEPTH)) u_pending (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(pend_waddr),
    .wdata_i(pend_wdata),
    .raddr_i(pend_raddr),
    .rdata_o(pend_rdata)
  );

  assign in_stall_o  = (state_q != npc_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == npc_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign vec_ok = ({1'b0, vec_q} < (VW + 1)'(npc_pkg::NUM_VECTORS));
  assign hw_outranks = (hw_cnt_q == '0) ||
      (npc_pkg::prio_of(prio_lo_q, prio_hi_q, vec_q) >
       npc_pkg::prio_of(prio_lo_q, prio_hi_q, hw_rdata));
  assign pend_outranks = (hw_cnt_q == '0) ||
      (best_prio_q > npc_pkg::prio_of(prio_lo_q, prio_hi_q, hw_rdata));
  assign scan_prio   = npc_pkg::prio_of(prio_lo_q, prio_hi_q, pend_rdata[VW-1:0]);
  assign pend_better = (scan_idx_q == '0) || (scan_prio > best_prio_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npc_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = npc_pkg::ST_READ;
        end
      end
      npc_pkg::ST_READ: begin
        if (npc_pkg::func_e'(func_q) == npc_pkg::FUNC_RETURN && nest_cnt_q != '0 &&
            pend_cnt_q != '0) begin
          state_d = npc_pkg::ST_SCAN;
        end else begin
          state_d = npc_pkg::ST_DONE;
        end
      end
      npc_pkg::ST_SCAN: begin
        if (PCW'(scan_idx_q) + PCW'(1) == pend_cnt_q) begin
          state_d = npc_pkg::ST_DECIDE;
        end
      end
      npc_pkg::ST_DECIDE: begin
        if (pend_outranks && nest_cnt_q < NCW'(npc_pkg::NEST_DEPTH) &&
            hw_cnt_q < NCW'(npc_pkg::NEST_DEPTH)) begin
          state_d = npc_pkg::ST_SHIFT;
        end else begin
          state_d = npc_pkg::ST_DONE;
        end
      end
      npc_pkg::ST_SHIFT: begin
        if (shift_idx_q >= pend_cnt_q) begin
          state_d = npc_pkg::ST_DONE;
        end
      end
      npc_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = npc_pkg::ST_IDLE;
        end
      end
      default: state_d = npc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    func_d      = func_q;
    vec_d       = vec_q;
    hw_cnt_d    = hw_cnt_q;
    nest_cnt_d  = nest_cnt_q;
    pend_cnt_d  = pend_cnt_q;
    arr_d       = arr_q;
    scan_idx_d  = scan_idx_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    best_vec_d  = best_vec_q;
    shift_idx_d = shift_idx_q;
    res_d       = res_q;
    hw_we       = 1'b0;
    hw_waddr    = NAW'(hw_cnt_q);
    hw_wdata    = vec_q;
    kind_we     = 1'b0;
    kind_waddr  = NAW'(nest_cnt_q);
    kind_wdata  = 1'b1;
    pend_we     = 1'b0;
    pend_waddr  = PAW'(pend_cnt_q);
    pend_wdata  = {arr_q, vec_q};
    pend_raddr  = '0;

    unique case (state_q)
      npc_pkg::ST_IDLE: begin
        if (in_accept) begin
          func_d = in_data_i.func;
          vec_d  = in_data_i.vector;
          res_d  = '0;
        end
      end
      npc_pkg::ST_READ: begin
        pend_raddr = '0;
        scan_idx_d = '0;
        unique case (npc_pkg::func_e'(func_q))
          npc_pkg::FUNC_HW_REQ: begin
            if (vec_ok) begin
              if (hw_outranks) begin
                if (nest_cnt_q >= NCW'(npc_pkg::NEST_DEPTH) ||
                    hw_cnt_q >= NCW'(npc_pkg::NEST_DEPTH)) begin
                  res_d.error_code = npc_pkg::ERR_NEST_FULL;
                end else begin
                  hw_we      = 1'b1;
                  kind_we    = 1'b1;
                  hw_cnt_d   = hw_cnt_q + NCW'(1);
                  nest_cnt_d = nest_cnt_q + NCW'(1);
                  res_d.dispatched        = 1'b1;
                  res_d.dispatched_vector = vec_q;
                end
              end else if (pend_cnt_q >= PCW'(npc_pkg::PENDING_DEPTH)) begin
                res_d.error_code = npc_pkg::ERR_PENDING_FULL;
              end else begin
                pend_we    = 1'b1;
                pend_cnt_d = pend_cnt_q + PCW'(1);
                arr_d      = arr_q + 8'd1;
                res_d.queued = 1'b1;
              end
            end
          end
          npc_pkg::FUNC_SW_ENTRY: begin
            if (vec_ok) begin
              if (nest_cnt_q >= NCW'(npc_pkg::NEST_DEPTH)) begin
                res_d.error_code = npc_pkg::ERR_NEST_FULL;
              end else begin
                kind_we    = 1'b1;
                kind_wdata = 1'b0;
                nest_cnt_d = nest_cnt_q + NCW'(1);
                res_d.dispatched        = 1'b1;
                res_d.dispatched_vector = vec_q;
              end
            end
          end
          npc_pkg::FUNC_RETURN: begin
            if (nest_cnt_q == '0) begin
              res_d.error_code = npc_pkg::ERR_NOTHING_ACTIVE;
            end else begin
              nest_cnt_d = nest_cnt_q - NCW'(1);
              if (kind_rdata && hw_cnt_q != '0) begin
                hw_cnt_d = hw_cnt_q - NCW'(1);
              end
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end
      npc_pkg::ST_SCAN: begin
        // Entry scan_idx_q arrives now; the next one is requested.
        pend_raddr = scan_idx_q + PAW'(1);
        scan_idx_d = scan_idx_q + PAW'(1);
        if (pend_better) begin
          best_idx_d  = scan_idx_q;
          best_prio_d = scan_prio;
          best_vec_d  = pend_rdata[VW-1:0];
        end
      end
      npc_pkg::ST_DECIDE: begin
        pend_raddr = best_idx_q + PAW'(1);
        shift_idx_d = PCW'(best_idx_q);
        if (pend_outranks && nest_cnt_q < NCW'(npc_pkg::NEST_DEPTH) &&
            hw_cnt_q < NCW'(npc_pkg::NEST_DEPTH)) begin
          hw_we      = 1'b1;
          hw_wdata   = best_vec_q;
          kind_we    = 1'b1;
          hw_cnt_d   = hw_cnt_q + NCW'(1);
          nest_cnt_d = nest_cnt_q + NCW'(1);
          pend_cnt_d = pend_cnt_q - PCW'(1);
          res_d.dispatched        = 1'b1;
          res_d.dispatched_vector = best_vec_q;
          res_d.from_pending      = 1'b1;
        end
      end
      npc_pkg::ST_SHIFT: begin
        // Close the gap: entry shift_idx_q + 1 arrives and moves down by one.
        pend_raddr = PAW'(shift_idx_q + PCW'(2));
        if (shift_idx_q < pend_cnt_q) begin
          pend_we     = 1'b1;
          pend_waddr  = PAW'(shift_idx_q);
          pend_wdata  = pend_rdata;
          shift_idx_d = shift_idx_q + PCW'(1);
        end
      end
      npc_pkg::ST_DONE: begin
        res_d.active_depth = 5'(nest_cnt_q);
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npc_pkg::ST_IDLE;
      hw_cnt_q    <= '0;
      nest_cnt_q  <= '0;
      pend_cnt_q  <= '0;
      arr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hw_cnt_q   <= hw_cnt_d;
      nest_cnt_q <= nest_cnt_d;
      pend_cnt_q <= pend_cnt_d;
      arr_q      <= arr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    vec_q       <= vec_d;
    scan_idx_q  <= scan_idx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_vec_q  <= best_vec_d;
    shift_idx_q <= shift_idx_d;
    res_q       <= res_d;
    if (out_load) begin
      out_q <= res_d;
    end
  end

endmodule

### rtl/core/npc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the stacks and the pending store of the interrupt controller.
module npc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
